[rtl/array_linked_list_engine_top_assert.svh]
// Assertion macros used by the linked list engine slot table.
`ifndef ARRAY_LINKED_LIST_ENGINE_TOP_ASSERT_SVH
`define ARRAY_LINKED_LIST_ENGINE_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define ALLE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define ALLE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/alle_pkg.sv]
// Package: command, status and word types of the linked list engine.
`timescale 1ns / 1ps
package alle_pkg;

  typedef enum logic [1:0] {
    CMD_INS_AFTER = 2'd0,
    CMD_INS_HEAD  = 2'd1,
    CMD_INS_TAIL  = 2'd2,
    CMD_DELETE    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_REFUSED = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  // Command word: one list operation
  typedef struct packed {
    cmd_t               cmd;
    logic [3:0]         slot_index;
    logic signed [31:0] item_value;
  } cmd_word_t;

  // Result word: outcome and list summary after the operation
  typedef struct packed {
    status_t    status;
    logic [3:0] new_slot;
    logic [3:0] head_slot;
    logic [3:0] tail_slot;
    logic [3:0] used_count;
  } res_word_t;

endpackage

[rtl/alle_cmd_if.sv]
// Interface: command channel (valid, ready, command word).
`timescale 1ns / 1ps
interface alle_cmd_if
  import alle_pkg::*;
  ;
  logic      valid;
  logic      ready;
  cmd_word_t word;

  modport source (output valid, output word, input ready);
  modport sink   (input valid, input word, output ready);
endinterface

[rtl/alle_res_if.sv]
// Interface: result channel (valid, ready, result word).
`timescale 1ns / 1ps
interface alle_res_if
  import alle_pkg::*;
  ;
  logic      valid;
  logic      ready;
  res_word_t word;

  modport source (output valid, output word, input ready);
  modport sink   (input valid, input word, output ready);
endinterface

[rtl/alle_in_stage.sv]
// Input register: holds one command word until the table takes it.
`timescale 1ns / 1ps
module alle_in_stage
  import alle_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  alle_cmd_if.sink   cmd_ch,
  input  logic       take,
  output logic       vld,
  output cmd_word_t  word
);

  // Refill whenever empty or emptied this cycle
  assign cmd_ch.ready = !vld || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (cmd_ch.ready) begin
      vld <= cmd_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_ch.valid && cmd_ch.ready) begin
      word <= cmd_ch.word;
    end
  end

endmodule

[rtl/alle_out_stage.sv]
// Output register: holds one result word until the consumer takes it.
`timescale 1ns / 1ps
module alle_out_stage
  import alle_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       load,
  input  res_word_t  word,
  output logic       space,
  alle_res_if.source res_ch
);

  // Free when empty or drained this cycle
  assign space = !res_ch.valid || res_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_ch.valid <= 1'b0;
    end else if (space) begin
      res_ch.valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && space) begin
      res_ch.word <= word;
    end
  end

endmodule

[rtl/alle_table.sv]
// Slot table: link arrays, free chain and single-pass command update.
`timescale 1ns / 1ps
`include "array_linked_list_engine_top_assert.svh"
module alle_table
  import alle_pkg::*;
#(
  parameter int SLOTS = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  cmd_word_t word,
  input  logic      commit,
  output res_word_t res
);

  localparam int PW = $clog2(SLOTS);
  typedef logic [PW-1:0] ptr_t;

  // Link state, flops so reset rebuilds the free chain at once
  ptr_t             nxt [SLOTS];
  ptr_t             prv [SLOTS];
  logic [SLOTS-1:0] used;
  ptr_t             free_head;
  ptr_t             item_count;

  // Stored values, never read back into a result
  logic [31:0]      val_mem [SLOTS];

  ptr_t             nxt_next [SLOTS];
  ptr_t             prv_next [SLOTS];
  logic [SLOTS-1:0] used_next;
  ptr_t             free_head_next;
  ptr_t             item_count_next;
  logic             wr_val;

  logic    idx_ok;
  ptr_t    idx_p;
  logic    anchor_ok;
  ptr_t    anchor;
  logic    anchor_live;
  logic    del_ok;
  status_t status;
  ptr_t    taken;

  // Decode the slot operand and the insert anchor
  assign idx_ok = 32'(word.slot_index) < SLOTS;
  assign idx_p  = PW'(word.slot_index);

  always_comb begin
    unique case (word.cmd)
      CMD_INS_AFTER: begin
        anchor_ok = idx_ok;
        anchor    = idx_p;
      end
      CMD_INS_HEAD: begin
        anchor_ok = 1'b1;
        anchor    = '0;
      end
      CMD_INS_TAIL: begin
        anchor_ok = 1'b1;
        anchor    = prv[0];
      end
      CMD_DELETE: begin
        anchor_ok = idx_ok;
        anchor    = idx_p;
      end
    endcase
  end

  assign anchor_live = anchor_ok && (anchor == '0 || used[anchor]);
  assign del_ok      = idx_ok && idx_p != '0 && used[idx_p];

  // Next link state and status; later writes win as in program order
  always_comb begin
    ptr_t p_s;
    ptr_t n_s;
    ptr_t after_s;
    nxt_next        = nxt;
    prv_next        = prv;
    used_next       = used;
    free_head_next  = free_head;
    item_count_next = item_count;
    status          = ST_DONE;
    taken           = '0;
    wr_val          = 1'b0;
    p_s             = prv[idx_p];
    n_s             = nxt[idx_p];
    after_s         = nxt[anchor];
    if (word.cmd == CMD_DELETE) begin
      if (!del_ok) begin
        status = ST_REFUSED;
      end else begin
        nxt_next[p_s]    = n_s;
        prv_next[n_s]    = p_s;
        used_next[idx_p] = 1'b0;
        nxt_next[idx_p]  = free_head;
        prv_next[idx_p]  = '0;
        free_head_next   = idx_p;
        item_count_next  = item_count - PW'(1);
      end
    end else if (!anchor_live) begin
      status = ST_REFUSED;
    end else if (free_head == '0) begin
      status = ST_FULL;
    end else begin
      free_head_next       = nxt[free_head];
      used_next[free_head] = 1'b1;
      nxt_next[anchor]     = free_head;
      prv_next[free_head]  = anchor;
      nxt_next[free_head]  = after_s;
      prv_next[after_s]    = free_head;
      item_count_next      = item_count + PW'(1);
      taken                = free_head;
      wr_val               = 1'b1;
    end
  end

  // Result word reflects the state after the command
  assign res.status     = status;
  assign res.new_slot   = 4'(taken);
  assign res.head_slot  = 4'(nxt_next[0]);
  assign res.tail_slot  = 4'(prv_next[0]);
  assign res.used_count = 4'(item_count_next);

  // Link state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        nxt[i] <= (i == 0 || i + 1 >= SLOTS) ? '0 : PW'(i + 1);
        prv[i] <= (i == 0) ? '0 : PW'(i - 1);
      end
      used       <= '0;
      free_head  <= PW'(1);
      item_count <= '0;
    end else if (commit) begin
      nxt        <= nxt_next;
      prv        <= prv_next;
      used       <= used_next;
      free_head  <= free_head_next;
      item_count <= item_count_next;
    end
  end

  // Value store, written at the slot an insert takes
  always_ff @(posedge clk) begin
    if (commit && wr_val) begin
      val_mem[free_head] <= word.item_value;
    end
  end

  `ALLE_ASSERT_IMP(a_full_count, free_head == '0, item_count == PW'(SLOTS - 1), "free chain empty but table not full")
  `ALLE_ASSERT_NXT(a_insert_count, commit && wr_val, item_count == PW'($past(item_count) + PW'(1)), "insert did not bump count")
  `ALLE_ASSERT_IMP(a_empty_head, 1'b1, (item_count == '0) == (nxt[0] == '0), "head and count disagree on empty list")

endmodule

[rtl/array_linked_list_engine_top.sv]
// Path: a command word accepted into the input register passes the slot table update
// and is held in the result register; it waits in the input register while that is full.
// Throughput: one command per cycle while the result register has room; each command
// is one pass through the slot table update between the input and result registers.
// Reset: synchronous rst rebuilds the free chain and empties the list;
// stored values stay undefined until written.
`timescale 1ns / 1ps
module array_linked_list_engine_top
  import alle_pkg::*;
#(
  parameter int SLOTS = 16
) (
  input  logic       clk,
  input  logic       rst,
  alle_cmd_if.sink   cmd_ch,
  alle_res_if.source res_ch
);

  logic      in_vld;
  cmd_word_t in_word;
  logic      out_space;
  logic      advance;
  res_word_t res;

  // Move a command through when the result register has room
  assign advance = in_vld && out_space;

  alle_in_stage u_in (
    .clk    (clk),
    .rst    (rst),
    .cmd_ch (cmd_ch),
    .take   (advance),
    .vld    (in_vld),
    .word   (in_word)
  );

  alle_table #(
    .SLOTS (SLOTS)
  ) u_table (
    .clk    (clk),
    .rst    (rst),
    .word   (in_word),
    .commit (advance),
    .res    (res)
  );

  alle_out_stage u_out (
    .clk    (clk),
    .rst    (rst),
    .load   (in_vld),
    .word   (res),
    .space  (out_space),
    .res_ch (res_ch)
  );

endmodule

[test/tb.sv]
// Testbench for the array linked list engine: directed and random commands, predicted results.
`timescale 1ns / 1ps
module tb;
  import alle_pkg::*;

  localparam int NSLOT      = 16;
  localparam int IDLE_LIMIT = 2000;
  localparam int HOLD_LEN   = 300;
  localparam int PHASE_LEN  = 410;

  // Table model plus queue of predicted result words
  class list_scoreboard;
    logic [3:0] link_next [NSLOT];
    logic [3:0] link_prev [NSLOT];
    bit         in_list [NSLOT];
    logic [3:0] free_top;
    logic [3:0] n_items;
    res_word_t  expected_results [$];
    int         errors;

    function new();
      for (int i = 0; i < NSLOT; i++) begin
        in_list[i]   = 1'b0;
        link_next[i] = (i == 0 || i + 1 >= NSLOT) ? 4'd0 : 4'(i + 1);
        link_prev[i] = (i == 0) ? 4'd0 : 4'(i - 1);
      end
      free_top = 4'd1;
      n_items  = 4'd0;
      errors   = 0;
    endfunction

    function bit is_live(logic [3:0] s);
      return s == 4'd0 || in_list[s];
    endfunction

    // Apply one command to the table and return the outcome
    function res_word_t apply_command(cmd_word_t w);
      res_word_t  r;
      logic [3:0] anchor;
      logic [3:0] p;
      logic [3:0] n;
      logic [3:0] after;
      logic [3:0] s;
      r.status   = ST_DONE;
      r.new_slot = 4'd0;
      if (w.cmd == CMD_DELETE) begin
        s = w.slot_index;
        if (s == 4'd0 || !in_list[s]) begin
          r.status = ST_REFUSED;
        end else begin
          p = link_prev[s];
          n = link_next[s];
          link_next[p] = n;
          link_prev[n] = p;
          in_list[s]   = 1'b0;
          link_next[s] = free_top;
          link_prev[s] = 4'd0;
          free_top     = s;
          n_items      = n_items - 4'd1;
        end
      end else begin
        case (w.cmd)
          CMD_INS_AFTER: anchor = w.slot_index;
          CMD_INS_HEAD:  anchor = 4'd0;
          default:       anchor = link_prev[0];
        endcase
        if (!is_live(anchor)) begin
          r.status = ST_REFUSED;
        end else if (free_top == 4'd0) begin
          r.status = ST_FULL;
        end else begin
          n     = free_top;
          after = link_next[anchor];
          free_top          = link_next[n];
          in_list[n]        = 1'b1;
          link_next[anchor] = n;
          link_prev[n]      = anchor;
          link_next[n]      = after;
          link_prev[after]  = n;
          n_items           = n_items + 4'd1;
          r.new_slot        = n;
        end
      end
      r.head_slot  = link_next[0];
      r.tail_slot  = link_prev[0];
      r.used_count = n_items;
      return r;
    endfunction

    function void note_command(cmd_word_t w);
      expected_results.push_back(apply_command(w));
    endfunction

    task report(string what, int got, int want);
      errors++;
      $display("[%0t] mismatch %s: got %0d want %0d", $time, what, got, want);
    endtask

    task check_result(res_word_t got);
      res_word_t want;
      if (expected_results.size() == 0) begin
        report("unexpected result word", int'(got), 0);
        return;
      end
      want = expected_results.pop_front();
      if (got.status !== want.status)
        report("status", int'(got.status), int'(want.status));
      if (got.new_slot !== want.new_slot)
        report("new_slot", int'(got.new_slot), int'(want.new_slot));
      if (got.head_slot !== want.head_slot)
        report("head_slot", int'(got.head_slot), int'(want.head_slot));
      if (got.tail_slot !== want.tail_slot)
        report("tail_slot", int'(got.tail_slot), int'(want.tail_slot));
      if (got.used_count !== want.used_count)
        report("used_count", int'(got.used_count), int'(want.used_count));
    endtask

    // A slot currently in the list, optionally the sentinel too
    function logic [3:0] pick_live(bit with_sentinel);
      logic [3:0] cand [$];
      if (with_sentinel) cand.push_back(4'd0);
      for (int i = 1; i < NSLOT; i++)
        if (in_list[i]) cand.push_back(4'(i));
      if (cand.size() == 0) return 4'd0;
      return cand[$urandom_range(cand.size() - 1)];
    endfunction
  endclass

  logic clk;
  logic rst;
  alle_cmd_if cmd_ch ();
  alle_res_if res_ch ();

  array_linked_list_engine_top #(.SLOTS(NSLOT)) uut (
    .clk    (clk),
    .rst    (rst),
    .cmd_ch (cmd_ch),
    .res_ch (res_ch)
  );

  list_scoreboard sb;
  int  send_idle_pct;
  int  recv_stall_pct;
  bit  hold_req;
  int  hold_left;
  int  idle_cycles;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result side: check accepted words, then decide ready for the next edge
  initial begin
    res_ch.ready <= 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && res_ch.valid && res_ch.ready) sb.check_result(res_ch.word);
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_LEN;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Watchdog: cycles with no word moving on either channel
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // Offer one command word and hold it until taken
  task automatic send_cmd(cmd_t c, logic [3:0] s, logic [31:0] v);
    cmd_word_t w;
    w.cmd        = c;
    w.slot_index = s;
    w.item_value = v;
    if ($urandom_range(99) < send_idle_pct) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.word  <= w;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    sb.note_command(w);
  endtask

  // Random command: mostly valid slots, biased to grow or shrink the list
  task automatic send_random(bit grow);
    cmd_t       c;
    logic [3:0] s;
    if ($urandom_range(99) < (grow ? 75 : 25)) begin
      case ($urandom_range(2))
        0:       c = CMD_INS_AFTER;
        1:       c = CMD_INS_HEAD;
        default: c = CMD_INS_TAIL;
      endcase
    end else begin
      c = CMD_DELETE;
    end
    if ($urandom_range(99) < 15) s = 4'($urandom_range(15));
    else s = sb.pick_live(c == CMD_INS_AFTER);
    send_cmd(c, s, $urandom);
  endtask

  initial begin
    int send_mix [4];
    int recv_mix [4];
    sb = new();
    send_mix = '{0, 55, 0, 35};
    recv_mix = '{0, 0, 55, 35};
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req       = 1'b0;
    rst            = 1'b1;
    cmd_ch.valid   <= 1'b0;
    cmd_ch.word    <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: refusals on empty list, extremes, every command, full table
    send_cmd(CMD_DELETE, 4'd0, 32'd0);
    send_cmd(CMD_DELETE, 4'd5, 32'hFFFF_FFFF);
    send_cmd(CMD_INS_AFTER, 4'd3, 32'h1234_5678);
    send_cmd(CMD_INS_TAIL, 4'd15, 32'h7FFF_FFFF);
    send_cmd(CMD_INS_HEAD, 4'd9, 32'h8000_0000);
    send_cmd(CMD_INS_AFTER, 4'd0, 32'hFFFF_FFFF);
    send_cmd(CMD_INS_AFTER, 4'd1, 32'd0);
    send_cmd(CMD_DELETE, 4'd2, 32'd0);
    send_cmd(CMD_DELETE, 4'd1, 32'd0);
    while (sb.n_items < 4'd15) send_cmd(CMD_INS_TAIL, 4'($urandom_range(15)), $urandom);
    send_cmd(CMD_INS_HEAD, 4'd0, 32'hA5A5_5A5A);
    send_cmd(CMD_INS_AFTER, 4'd0, 32'h5A5A_A5A5);
    send_cmd(CMD_DELETE, 4'd0, 32'd0);
    send_cmd(CMD_DELETE, sb.link_prev[0], 32'd0);
    send_cmd(CMD_INS_AFTER, 4'd15, 32'hDEAD_BEEF);

    // Random phases with varying idle and stall rates
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = send_mix[ph];
      recv_stall_pct = recv_mix[ph];
      if (ph == 0) hold_req = 1'b1;
      for (int k = 0; k < PHASE_LEN; k++) send_random(((k / 40) % 2) == 0);
    end
    cmd_ch.valid <= 1'b0;

    // Drain, then let the pipeline settle
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[array_linked_list_engine_top.f]
+incdir+rtl
rtl/alle_pkg.sv
rtl/alle_cmd_if.sv
rtl/alle_res_if.sv
rtl/alle_in_stage.sv
rtl/alle_out_stage.sv
rtl/alle_table.sv
rtl/array_linked_list_engine_top.sv
test/tb.sv
